// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// non-overlapped implication from antecedent to consequent, skipped while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// non-overlapped implication from antecedent to consequent, also checked through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/sorh_pkg.sv -----
// shared types and constants for the interval-or histogram block
// no dependencies; used by the controller, datapath, top and checker by scoped names
package sorh_pkg;

   // default sizes of the block
   localparam int MASK_BITS_DEF      = 16;
   localparam int COUNT_BITS_DEF     = 48;
   localparam int RUN_COUNT_BITS_DEF = 32;

   // fixed widths of the stream fields
   localparam int LETTER_BITS = 16;
   localparam int OUT_BITS    = 48;
   localparam int OP_BITS     = 2;

   // operation codes carried in req_tuser
   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // controller states, one-hot
   typedef enum logic [4:0] {
      ST_SWEEP = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_READ  = 5'b10000
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic push_start;
      logic scan_step;
      logic final_emit;
      logic read_start;
      logic rsp_load;
      logic sweep_step;
      logic profile_clear;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic letter_nonzero;
      logic scan_done;
      logic sweep_done;
      logic rsp_free;
   } status_type;

endpackage

// ----- rtl/core/sorh_ram.sv -----
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module sorh_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sorh_ctrl.sv -----
// controller state machine for the interval-or histogram block
// depends on sorh_pkg
module sorh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  sorh_pkg::op_type     op,
   input  sorh_pkg::status_type status,
   output sorh_pkg::cmd_type    cmd
);

   sorh_pkg::state_type state_ff, state_in;

   // state register, reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sorh_pkg::ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == sorh_pkg::ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         sorh_pkg::ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_done) begin
               state_in = sorh_pkg::ST_IDLE;
            end
         end
         sorh_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               case (op)
                  sorh_pkg::OP_PUSH: begin
                     // a zero letter changes nothing
                     if (status.letter_nonzero) begin
                        cmd.push_start = 1'b1;
                        state_in       = sorh_pkg::ST_SCAN;
                     end
                  end
                  sorh_pkg::OP_READ: begin
                     cmd.read_start = 1'b1;
                     state_in       = sorh_pkg::ST_READ;
                  end
                  sorh_pkg::OP_CLEAR: begin
                     cmd.profile_clear = 1'b1;
                     state_in          = sorh_pkg::ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         sorh_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               cmd.final_emit = 1'b1;
               state_in       = sorh_pkg::ST_DRAIN;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         sorh_pkg::ST_DRAIN: begin
            // last histogram write-back lands in this cycle
            state_in = sorh_pkg::ST_IDLE;
         end
         sorh_pkg::ST_READ: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = sorh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sorh_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/sorh_datapath.sv -----
// datapath: run profile, histogram ram with read-modify-write, output register
// depends on sorh_pkg and sorh_ram
module sorh_datapath #(
   parameter int MASK_BITS      = sorh_pkg::MASK_BITS_DEF,
   parameter int COUNT_BITS     = sorh_pkg::COUNT_BITS_DEF,
   parameter int RUN_COUNT_BITS = sorh_pkg::RUN_COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [sorh_pkg::LETTER_BITS-1:0] letter,
   input  logic [sorh_pkg::LETTER_BITS-1:0] read_mask,
   input  sorh_pkg::cmd_type                cmd,
   output sorh_pkg::status_type             status,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sorh_pkg::OUT_BITS-1:0]    rsp_count
);

   localparam int MB     = MASK_BITS;
   localparam int CW     = COUNT_BITS;
   localparam int RW     = RUN_COUNT_BITS;
   localparam int DEPTH  = MASK_BITS + 1;
   localparam int IDXW   = $clog2(DEPTH);
   localparam int CNTW   = $clog2(DEPTH + 1);
   localparam int HDEPTH = 2 ** MASK_BITS;
   localparam int SUMW   = ((CW > RW) ? CW : RW) + 1;
   localparam int OW     = sorh_pkg::OUT_BITS;
   localparam int WIDE   = (CW > OW) ? CW : OW;

   // run profile, no reset: only the first run_total entries are read
   logic [MB-1:0]   run_mask_ff [DEPTH];
   logic [MB-1:0]   run_mask_in [DEPTH];
   logic [RW-1:0]   run_cnt_ff  [DEPTH];
   logic [RW-1:0]   run_cnt_in  [DEPTH];
   logic [CNTW-1:0] run_total_ff, run_total_in;

   // scan state
   logic [MB-1:0]   letter_ff, letter_in;
   logic [MB-1:0]   pend_mask_ff, pend_mask_in;
   logic [RW-1:0]   pend_cnt_ff, pend_cnt_in;
   logic [CNTW-1:0] idx_ff, idx_in;
   logic [IDXW-1:0] out_idx_ff, out_idx_in;

   // histogram write-back stage
   logic            wb_valid_ff, wb_valid_in;
   logic [MB-1:0]   wb_addr_ff, wb_addr_in;
   logic [RW-1:0]   wb_cnt_ff, wb_cnt_in;

   // clearing sweep counter
   logic [MB-1:0]   sweep_cnt_ff, sweep_cnt_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]   rsp_data_ff, rsp_data_in;

   logic [MB-1:0]   letter_v;
   logic [MB-1:0]   scan_mask;
   logic [RW-1:0]   scan_cnt;
   logic            mask_differs;
   logic            emit;
   logic [RW:0]     run_sum;
   logic [RW-1:0]   run_sat;
   logic [SUMW-1:0] hist_sum;
   logic [SUMW-1:0] hist_lim;
   logic [CW-1:0]   hist_sat;
   logic [WIDE-1:0] rd_wide;
   logic [WIDE-1:0] out_max;
   logic            ram_wr_en;
   logic [MB-1:0]   ram_wr_addr;
   logic [CW-1:0]   ram_wr_data;
   logic            ram_rd_en;
   logic [MB-1:0]   ram_rd_addr;
   logic [CW-1:0]   ram_rd_data;

   // letter bits above the mask width are ignored
   assign letter_v = MB'(letter);

   // old run combined with the current letter
   assign scan_mask    = run_mask_ff[idx_ff[IDXW-1:0]] | letter_ff;
   assign scan_cnt     = run_cnt_ff[idx_ff[IDXW-1:0]];
   assign mask_differs = (scan_mask != pend_mask_ff);
   assign emit         = cmd.final_emit | (cmd.scan_step & mask_differs);

   // saturating merge of equal neighbouring runs
   assign run_sum = {1'b0, pend_cnt_ff} + {1'b0, scan_cnt};
   assign run_sat = run_sum[RW] ? {RW{1'b1}} : run_sum[RW-1:0];

   // saturating histogram update
   assign hist_lim = SUMW'({CW{1'b1}});
   assign hist_sum = SUMW'(ram_rd_data) + SUMW'(wb_cnt_ff);
   assign hist_sat = (hist_sum >= hist_lim) ? {CW{1'b1}} : hist_sum[CW-1:0];

   // profile and scan registers
   always_comb begin
      run_mask_in  = run_mask_ff;
      run_cnt_in   = run_cnt_ff;
      run_total_in = run_total_ff;
      letter_in    = letter_ff;
      pend_mask_in = pend_mask_ff;
      pend_cnt_in  = pend_cnt_ff;
      idx_in       = idx_ff;
      out_idx_in   = out_idx_ff;
      if (cmd.push_start) begin
         letter_in    = letter_v;
         pend_mask_in = letter_v;
         pend_cnt_in  = RW'(1);
         idx_in       = '0;
         out_idx_in   = '0;
      end
      if (emit) begin
         run_mask_in[out_idx_ff] = pend_mask_ff;
         run_cnt_in[out_idx_ff]  = pend_cnt_ff;
      end
      if (cmd.scan_step) begin
         idx_in = idx_ff + CNTW'(1);
         if (mask_differs) begin
            pend_mask_in = scan_mask;
            pend_cnt_in  = scan_cnt;
            out_idx_in   = out_idx_ff + IDXW'(1);
         end else begin
            pend_cnt_in = run_sat;
         end
      end
      if (cmd.final_emit) begin
         run_total_in = CNTW'(out_idx_ff) + CNTW'(1);
      end
      if (cmd.profile_clear) begin
         run_total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      run_mask_ff  <= run_mask_in;
      run_cnt_ff   <= run_cnt_in;
      letter_ff    <= letter_in;
      pend_mask_ff <= pend_mask_in;
      pend_cnt_ff  <= pend_cnt_in;
      idx_ff       <= idx_in;
      out_idx_ff   <= out_idx_in;
      wb_addr_ff   <= wb_addr_in;
      wb_cnt_ff    <= wb_cnt_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_total_ff <= '0;
         wb_valid_ff  <= 1'b0;
         sweep_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_total_ff <= run_total_in;
         wb_valid_ff  <= wb_valid_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // write-back stage registers each emitted run
   assign wb_valid_in = emit;
   assign wb_addr_in  = emit ? pend_mask_ff : wb_addr_ff;
   assign wb_cnt_in   = emit ? pend_cnt_ff : wb_cnt_ff;

   // sweep counter wraps back to zero at the end of a pass
   assign sweep_cnt_in = cmd.sweep_step ? sweep_cnt_ff + MB'(1) : sweep_cnt_ff;

   // histogram ram ports
   always_comb begin
      ram_wr_en   = wb_valid_ff;
      ram_wr_addr = wb_addr_ff;
      ram_wr_data = hist_sat;
      if (cmd.sweep_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sweep_cnt_ff;
         ram_wr_data = '0;
      end
   end

   assign ram_rd_en   = emit | cmd.read_start;
   assign ram_rd_addr = emit ? pend_mask_ff : MB'(read_mask);

   sorh_ram #(
      .WIDTH (CW),
      .DEPTH (HDEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output word, clipped to the field width
   assign rd_wide = WIDE'(ram_rd_data);
   assign out_max = WIDE'({OW{1'b1}});

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (rd_wide > out_max) ? {OW{1'b1}} : rd_wide[OW-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_count  = rsp_data_ff;

   // status to the controller
   assign status.letter_nonzero = |letter_v;
   assign status.scan_done      = (idx_ff == run_total_ff);
   assign status.sweep_done     = &sweep_cnt_ff;
   assign status.rsp_free       = ~rsp_valid_ff | rsp_tready;

endmodule

// ----- rtl/core/subarray_or_histogram.sv -----
// top level of the interval-or histogram block
// depends on sorh_pkg, sorh_ctrl, sorh_datapath (and sorh_ram below it)
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tdata: letter, read_mask; tuser: op
//  rsp      out        rsp_tvalid/rsp_tready  tdata: interval_count
//
// a push of a nonzero letter steps through the scan state, one profile run per
// cycle and at most one histogram read-modify-write per cycle through the single
// histogram ram, then the drain state for the last write-back; a zero letter or an
// unused op leaves the block idle
// a read passes through the read state, which waits until the output register is free
// reset and clear each run a zeroing pass over all 2^MASK_BITS entries of the ram,
// req_tready stays low during it
// a stalled result holds in the output register while the next word is taken
module subarray_or_histogram #(
   parameter int MASK_BITS      = sorh_pkg::MASK_BITS_DEF,
   parameter int COUNT_BITS     = sorh_pkg::COUNT_BITS_DEF,
   parameter int RUN_COUNT_BITS = sorh_pkg::RUN_COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [15:0] letter, [31:16] read_mask
   input  logic [1:0]  req_tuser,  // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // [47:0] interval_count
);

   sorh_pkg::cmd_type    cmd;
   sorh_pkg::status_type status;

   // controller
   sorh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (sorh_pkg::op_type'(req_tuser)),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   sorh_datapath #(
      .MASK_BITS      (MASK_BITS),
      .COUNT_BITS     (COUNT_BITS),
      .RUN_COUNT_BITS (RUN_COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .letter     (req_tdata[15:0]),
      .read_mask  (req_tdata[31:16]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_count  (rsp_tdata)
   );

endmodule

// ----- rtl/core/sorh_checker.sv -----
// port-level checker for the interval-or histogram block, bound to the top
// depends on sorh_pkg and assert_macros.svh
`include "assert_macros.svh"

module sorh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   logic req_word;
   assign req_word = req_tvalid && req_tready;

   // stalled result word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word dropped or changed under stall")

   // the zeroing pass follows reset
   `ASSERT_NEXT_ALWAYS(a_sweep_after_reset, clock, reset, !req_tready, "req_tready high right after reset")

   // no result appears in the cycle after any accepted word
   `ASSERT_NEXT(a_no_early_rsp, clock, reset, req_word, !$rose(rsp_tvalid), "result too early")

   // a clear starts the zeroing pass
   `ASSERT_NEXT(a_clear_busy, clock, reset, req_word && (req_tuser == sorh_pkg::OP_CLEAR), !req_tready, "ready during clear pass")

   // a zero letter leaves the block idle
   `ASSERT_NEXT(a_zero_push_idle, clock, reset, req_word && (req_tuser == sorh_pkg::OP_PUSH) && (req_tdata[15:0] == 16'd0), req_tready, "zero letter made the block busy")

endmodule

bind subarray_or_histogram sorh_checker u_checker (.*);

// ----- sim/tb.sv -----
// testbench for subarray_or_histogram: directed and random words checked against
// a behavioural interval-or histogram kept inside the bench
// depends on sorh_pkg and the rtl of the block only
`timescale 1ns / 1ps

module tb;

   // sizes of the block, default build
   localparam int MASK_W      = sorh_pkg::MASK_BITS_DEF;
   localparam int COUNT_W     = sorh_pkg::COUNT_BITS_DEF;
   localparam int RUN_COUNT_W = sorh_pkg::RUN_COUNT_BITS_DEF;
   localparam int HIST_SIZE   = 1 << MASK_W;
   localparam int RUN_SLOTS   = MASK_W + 2;

   localparam logic [15:0] LETTER_MASK = 16'((32'd1 << MASK_W) - 1);
   localparam longint unsigned HIST_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_W);
   localparam longint unsigned RUN_MAX  = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - RUN_COUNT_W);
   localparam longint unsigned OUT_MAX  = 64'hFFFF_FFFF_FFFF_FFFF >> 16;

   // op code the block leaves unused
   localparam logic [1:0] OP_SPARE = 2'd3;

   // run shape
   localparam int N_WORDS      = 1250;
   localparam int CALM_LO      = 250;
   localparam int CALM_HI      = 500;
   localparam int HOLD_AT      = 700;
   localparam int HOLD_LEN     = 500;
   localparam int WATCHDOG     = 400000;
   localparam int END_SETTLE   = 64;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [1:0]  op;
      logic [15:0] letter;
      logic [15:0] read_mask;
      bit          hold_for_idle;
   } word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // [15:0] letter, [31:16] read_mask
   logic [1:0]  req_tuser = '0;  // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;       // [47:0] interval_count

   subarray_or_histogram u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // pending words and expected interval counts
   word_type    word_q[$];
   logic [47:0] count_q[$];
   word_type    on_bus;

   // predicted state: suffix-or profile and histogram
   logic [15:0]     prof_mask  [RUN_SLOTS];
   longint unsigned prof_count [RUN_SLOTS];
   int              prof_len = 0;
   longint unsigned tally [HIST_SIZE];

   // progress counters
   int words_sent = 0;
   int reads_acc = 0;
   int results_seen = 0;
   int misses = 0;
   int checked = 0;
   int n_push = 0, n_zero = 0, n_read = 0, n_clear = 0, n_spare = 0, deepest = 0;

   // generator bookkeeping
   logic [15:0] recent[$];
   int ignored = 0;

   function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                               longint unsigned lim);
      if (a >= lim || b >= lim - a)
         return lim;
      return a + b;
   endfunction

   // rebuild the profile for one nonzero letter and add its runs into the histogram
   task automatic fold_letter(logic [15:0] v);
      logic [15:0]     nm [RUN_SLOTS];
      longint unsigned nc [RUN_SLOTS];
      logic [15:0]     m;
      int              n;
      n = 1;
      nm[0] = v;
      nc[0] = 1;
      for (int i = 0; i < prof_len; i++) begin
         m = prof_mask[i] | v;
         if (nm[n-1] == m) begin
            nc[n-1] = sat_sum(nc[n-1], prof_count[i], RUN_MAX);
         end else if (n < RUN_SLOTS) begin
            nm[n] = m;
            nc[n] = prof_count[i];
            n++;
         end
      end
      for (int i = 0; i < n; i++) begin
         m = nm[i] & LETTER_MASK;
         tally[m] = sat_sum(tally[m], nc[i], HIST_MAX);
         prof_mask[i]  = nm[i];
         prof_count[i] = nc[i];
      end
      prof_len = n;
      if (n > deepest) deepest = n;
   endtask

   // effect of one accepted word on the predicted state
   task automatic apply_word(word_type w);
      logic [15:0]     key;
      longint unsigned h;
      case (w.op)
         sorh_pkg::OP_PUSH: begin
            key = w.letter & LETTER_MASK;
            n_push++;
            if (key != 0) fold_letter(key);
            else n_zero++;
         end
         sorh_pkg::OP_READ: begin
            key = w.read_mask & LETTER_MASK;
            h = tally[key];
            count_q.insert(count_q.size(), 48'(h > OUT_MAX ? OUT_MAX : h));
            n_read++;
         end
         sorh_pkg::OP_CLEAR: begin
            prof_len = 0;
            for (int i = 0; i < HIST_SIZE; i++) tally[i] = 0;
            n_clear++;
         end
         default: n_spare++;
      endcase
   endtask

   function automatic bit calm_phase();
      return words_sent >= CALM_LO && words_sent < CALM_HI;
   endfunction

   // sender: presents words from the pending queue
   always @(posedge clock) begin : word_driver
      bit go;
      bit took_read;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         took_read = 1'b0;
         if (req_tvalid && req_tready) begin
            apply_word(on_bus);
            took_read = (on_bus.op == sorh_pkg::OP_READ);
            words_sent <= words_sent + 1;
            if (took_read) reads_acc <= reads_acc + 1;
         end
         if (!req_tvalid || req_tready) begin
            go = word_q.size() != 0 && (calm_phase() || $urandom_range(99) >= 9);
            // pause until every outstanding count has come back
            if (go && word_q[0].hold_for_idle)
               go = (reads_acc + int'(took_read) == results_seen);
            if (go) begin
               on_bus = word_q.pop_front();
               req_tdata <= {on_bus.read_mask, on_bus.letter};
               req_tuser <= on_bus.op;
            end
            req_tvalid <= go;
         end
      end
   end

   // receiver: random back-pressure, one long hold-off, checks every count
   always @(posedge clock) begin : count_monitor
      int          hold_left;
      bit          hold_done;
      logic [47:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (count_q.size() == 0) begin
               misses++;
               if (misses <= MAX_REPORTS)
                  $display("unexpected interval count %0d with no read outstanding",
                           rsp_tdata);
            end else begin
               want = count_q.pop_front();
               checked++;
               if (rsp_tdata !== want) begin
                  misses++;
                  if (misses <= MAX_REPORTS)
                     $display("interval count mismatch: expected %0d, got %0d",
                              want, rsp_tdata);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && words_sent >= HOLD_AT) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm_phase() || $urandom_range(99) >= 9;
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin : stall_watch
      int quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= WATCHDOG) begin
         $display("no word moved for %0d cycles", quiet);
         $display("** subarray_or_histogram: FAILED **");
         $finish;
      end
   end

   task automatic queue_word(logic [1:0] op, logic [15:0] letter, logic [15:0] read_mask,
                             bit hold_for_idle = 1'b0);
      word_type w;
      w.op = op;
      w.letter = letter;
      w.read_mask = read_mask;
      w.hold_for_idle = hold_for_idle;
      word_q.insert(word_q.size(), w);
      if (op == OP_SPARE || (op == sorh_pkg::OP_PUSH && letter == 0)) ignored++;
      if (op == sorh_pkg::OP_PUSH && letter != 0) begin
         recent.push_front(letter);
         if (recent.size() > 32) recent.delete(recent.size() - 1);
      end
   endtask

   // or of a few consecutive recent letters, so that reads mostly hit live entries
   function automatic logic [15:0] interval_mask();
      logic [15:0] m;
      int          len, start;
      if (recent.size() == 0 || $urandom_range(3) == 0)
         return 16'($urandom);
      len = $urandom_range(1, recent.size() < 8 ? recent.size() : 8);
      start = $urandom_range(0, recent.size() - len);
      m = '0;
      for (int i = start; i < start + len; i++) m |= recent[i];
      return m;
   endfunction

   function automatic logic [15:0] any_letter();
      case ($urandom_range(5))
         0: return 16'h0001 << $urandom_range(15);
         1: return (16'h0001 << $urandom_range(15)) | (16'h0001 << $urandom_range(15));
         2: return 16'($urandom);
         3: return 16'hFFFF;
         4: return 16'($urandom & $urandom & $urandom);
         default: return 16'h0000;
      endcase
   endfunction

   initial begin : stimulus
      int          order [16];
      int          len, j, t;
      bit          first_clear, second_clear, read_burst, late_pause;
      logic [15:0] v;

      for (int i = 0; i < HIST_SIZE; i++) tally[i] = 0;
      first_clear = 0;
      second_clear = 0;
      read_burst = 0;
      late_pause = 0;

      // directed: empty reads, zero letter, merging, clear, spread bits, spare op
      queue_word(sorh_pkg::OP_READ,  16'h0000, 16'h0000);
      queue_word(sorh_pkg::OP_READ,  16'hFFFF, 16'hFFFF);
      queue_word(sorh_pkg::OP_PUSH,  16'h0000, 16'hFFFF);
      queue_word(sorh_pkg::OP_READ,  16'h0000, 16'h0000);
      queue_word(sorh_pkg::OP_PUSH,  16'hFFFF, 16'h0000);
      queue_word(sorh_pkg::OP_PUSH,  16'hFFFF, 16'h0000);
      queue_word(sorh_pkg::OP_READ,  16'h0000, 16'hFFFF);
      queue_word(sorh_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
      queue_word(sorh_pkg::OP_READ,  16'h0000, 16'hFFFF);
      queue_word(sorh_pkg::OP_PUSH,  16'h0001, 16'h0000);
      queue_word(sorh_pkg::OP_PUSH,  16'h0002, 16'h0000);
      queue_word(sorh_pkg::OP_PUSH,  16'h8000, 16'h0000);
      queue_word(sorh_pkg::OP_PUSH,  16'h0000, 16'h0000);
      queue_word(sorh_pkg::OP_READ,  16'h0000, 16'h0003);
      queue_word(sorh_pkg::OP_READ,  16'h0000, 16'h8003);
      queue_word(sorh_pkg::OP_READ,  16'h0000, 16'h0001);
      queue_word(sorh_pkg::OP_READ,  16'h0000, 16'h8000);
      queue_word(OP_SPARE,           16'hFFFF, 16'hFFFF);
      queue_word(sorh_pkg::OP_READ,  16'h0000, 16'hFFFF);
      queue_word(sorh_pkg::OP_PUSH,  16'hAAAA, 16'h5555);
      queue_word(sorh_pkg::OP_PUSH,  16'h5555, 16'hAAAA);
      queue_word(sorh_pkg::OP_READ,  16'hFFFF, 16'hFFFF);
      queue_word(sorh_pkg::OP_READ,  16'h0000, 16'h5555);

      // random part, mostly runs of pushes followed by reads of their intervals
      while (word_q.size() - ignored < N_WORDS) begin
         if (!first_clear && word_q.size() >= 450) begin
            first_clear = 1;
            queue_word(sorh_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 1'b1);
         end else if (!second_clear && word_q.size() >= 950) begin
            second_clear = 1;
            queue_word(sorh_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
         end else if (!read_burst && word_q.size() >= HOLD_AT - 5) begin
            // reads bunched around the long receiver hold-off
            read_burst = 1;
            repeat (30) queue_word(sorh_pkg::OP_READ, 16'($urandom), interval_mask());
         end else if (!late_pause && word_q.size() >= 1100) begin
            late_pause = 1;
            queue_word(sorh_pkg::OP_READ, 16'($urandom), interval_mask(), 1'b1);
         end else begin
            t = $urandom_range(99);
            if (t < 45) begin
               len = $urandom_range(4, 16);
               if ($urandom_range(1) == 0) begin
                  // distinct single bits in shuffled order build a deep profile
                  for (int i = 0; i < 16; i++) order[i] = i;
                  for (int i = 15; i > 0; i--) begin
                     j = $urandom_range(i);
                     t = order[i];
                     order[i] = order[j];
                     order[j] = t;
                  end
                  for (int i = 0; i < len; i++)
                     queue_word(sorh_pkg::OP_PUSH, 16'h0001 << order[i], 16'($urandom));
               end else begin
                  for (int i = 0; i < len; i++) begin
                     v = 16'($urandom & $urandom);
                     if (v == 0) v = 16'h0001 << $urandom_range(15);
                     queue_word(sorh_pkg::OP_PUSH, v, 16'($urandom));
                  end
               end
               repeat ($urandom_range(2, 4))
                  queue_word(sorh_pkg::OP_READ, 16'($urandom), interval_mask());
            end else if (t < 65) begin
               queue_word(sorh_pkg::OP_PUSH, any_letter(), 16'($urandom));
            end else if (t < 90) begin
               queue_word(sorh_pkg::OP_READ, 16'($urandom), interval_mask());
            end else if (t < 96) begin
               queue_word(OP_SPARE, 16'($urandom), 16'($urandom));
            end else begin
               repeat ($urandom_range(3, 8))
                  queue_word(sorh_pkg::OP_READ, 16'($urandom), interval_mask());
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // wait for the queue to empty and every count to come back
      while (word_q.size() != 0 || req_tvalid || reads_acc != results_seen)
         @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);

      $display("covered %0d pushes (%0d zero), %0d reads, %0d clears, %0d spare-op words",
               n_push, n_zero, n_read, n_clear, n_spare);
      $display("%0d interval counts compared, deepest profile %0d runs", checked, deepest);
      if (count_q.size() != 0)
         $display("%0d interval counts never arrived", count_q.size());
      if (misses == 0 && count_q.size() == 0)
         $display("** subarray_or_histogram: PASSED **");
      else
         $display("** subarray_or_histogram: FAILED **");
      $finish;
   end

endmodule
